// ===== rtl/trpd_pkg.sv =====
// ============================================================================
// TGA run-length pixel decoder package
// Shared types, codes and reset values for the decoder modules.
// ============================================================================
package trpd_pkg;

   localparam int PALETTE_ENTRIES_DEFAULT = 256;
   localparam int PALETTE_WIDTH = 24;

   // Request opcodes
   localparam logic [1:0] OP_START   = 2'd0;
   localparam logic [1:0] OP_PALETTE = 2'd1;
   localparam logic [1:0] OP_PIXEL   = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] CSR_DEPTH_CODE    = 2'd0;
   localparam logic [1:0] CSR_ALPHA_PRESENT = 2'd1;
   localparam logic [1:0] CSR_RLE_ENABLED   = 2'd2;
   localparam logic [1:0] CSR_IMAGE_PIXELS  = 2'd3;

   // Pixel depth codes
   localparam logic [1:0] DEPTH_PAL8 = 2'd0;
   localparam logic [1:0] DEPTH_16   = 2'd1;
   localparam logic [1:0] DEPTH_24   = 2'd2;
   localparam logic [1:0] DEPTH_32   = 2'd3;

   // Palette byte channels
   localparam logic [1:0] CHAN_BLUE  = 2'd0;
   localparam logic [1:0] CHAN_GREEN = 2'd1;
   localparam logic [1:0] CHAN_RED   = 2'd2;

   // Reset values of the configuration registers
   localparam logic [1:0]  DEPTH_RESET  = DEPTH_24;
   localparam logic [31:0] PIXELS_RESET = 32'd1;

   localparam logic [7:0] RUN_FLAG_MASK  = 8'h80;
   localparam logic [7:0] COUNT_MASK     = 8'h7F;
   localparam logic [7:0] CHANNEL_FULL   = 8'd255;

   // A completed pixel heading for the palette stage
   typedef struct packed {
      logic       valid;
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      logic [7:0] b3;
      logic [1:0] depth;
      logic       alpha_present;
      logic [7:0] repeat_count;
      logic       image_done;
      logic       run_clipped;
   } trpd_pixel_type;

   // A palette byte write heading for the palette stage
   typedef struct packed {
      logic       valid;
      logic [7:0] index;
      logic [1:0] channel;
      logic [7:0] data;
   } trpd_palwr_type;

endpackage

// ===== rtl/tga_rle_pixel_decoder.sv =====
// A pixel result passes through the s1 register and then the result register.
// Throughput: one request per cycle while req_stall is low; the palette RAM port
// does one read-modify-write per cycle, last write forwarded to a same-entry read.
// Reset (synchronous): configuration returns to 24-bit, no RLE, one pixel; stream
// state clears; palette contents are not cleared and no clearing pass is needed.
// ============================================================================
// TGA run-length pixel decoder
// Parses the TGA pixel byte stream with RLE packets and emits each pixel once
// as RGBA with a repeat count, using a palette RAM for 8-bit images.
// ============================================================================
module tga_rle_pixel_decoder #(
   parameter int PALETTE_ENTRIES = trpd_pkg::PALETTE_ENTRIES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_data_byte,
   input  logic [7:0]  req_palette_index,
   input  logic [1:0]  req_palette_channel,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [7:0]  rsp_alpha,
   output logic [7:0]  rsp_repeat_count,
   output logic        rsp_key_hit,
   output logic        rsp_image_done,
   output logic        rsp_run_clipped
);
   import trpd_pkg::*;

   trpd_pixel_type pix;
   trpd_palwr_type palwr;
   logic           hold;
   logic           req_accept;

   assign req_stall  = hold;
   assign req_accept = req_valid && !hold;

   trpd_stream u_stream (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .req_accept          (req_accept),
      .req_opcode          (req_opcode),
      .req_data_byte       (req_data_byte),
      .req_palette_index   (req_palette_index),
      .req_palette_channel (req_palette_channel),
      .pix                 (pix),
      .palwr               (palwr)
   );

   trpd_pixel #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_pixel (
      .clock            (clock),
      .reset            (reset),
      .pix              (pix),
      .palwr            (palwr),
      .hold             (hold),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_alpha        (rsp_alpha),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_key_hit      (rsp_key_hit),
      .rsp_image_done   (rsp_image_done),
      .rsp_run_clipped  (rsp_run_clipped)
   );

endmodule

// ===== rtl/trpd_ram.sv =====
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port; read data is registered (old data is
// returned when reading the address being written).
// ============================================================================
module trpd_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_addr] <= write_data;
      end
      read_data_ff <= mem[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

// ===== rtl/trpd_stream.sv =====
// ============================================================================
// Stream parser
// Holds the configuration registers and the packet, byte-gather and pixel
// count state; turns accepted requests into pixel and palette-write items.
// ============================================================================
module trpd_stream (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [1:0]                 csr_index,
   input  logic [31:0]                csr_write_data,
   input  logic                       req_accept,
   input  logic [1:0]                 req_opcode,
   input  logic [7:0]                 req_data_byte,
   input  logic [7:0]                 req_palette_index,
   input  logic [1:0]                 req_palette_channel,
   output trpd_pkg::trpd_pixel_type   pix,
   output trpd_pkg::trpd_palwr_type   palwr
);
   import trpd_pkg::*;

   logic [1:0]  depth_ff, depth_in;
   logic        alpha_ff, alpha_in;
   logic        rle_ff, rle_in;
   logic [31:0] pixels_ff, pixels_in;

   logic [23:0] gather_ff, gather_in;
   logic [1:0]  pos_ff, pos_in;
   logic [7:0]  remain_ff, remain_in;
   logic        is_run_ff, is_run_in;
   logic [31:0] done_ff, done_in;

   logic        pixel_byte;
   logic        header_byte;
   logic        pos_last;
   logic [31:0] left;
   logic [7:0]  repeat_count;
   logic        clipped;
   logic [7:0]  b0, b1, b2, b3;
   logic [7:0]  remain_dec;

   always_comb begin
      depth_in  = depth_ff;
      alpha_in  = alpha_ff;
      rle_in    = rle_ff;
      pixels_in = pixels_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DEPTH_CODE:    depth_in  = csr_write_data[1:0];
            CSR_ALPHA_PRESENT: alpha_in  = csr_write_data[0];
            CSR_RLE_ENABLED:   rle_in    = csr_write_data[0];
            CSR_IMAGE_PIXELS:  pixels_in = csr_write_data;
            default:           depth_in  = depth_ff;
         endcase
      end
   end

   // Pixel bytes count only while the image is still incomplete.
   assign pixel_byte  = req_accept && (req_opcode == OP_PIXEL) && (done_ff < pixels_ff);
   assign header_byte = rle_ff && (remain_ff == 8'd0);
   assign pos_last    = (pos_ff >= depth_ff);
   assign left        = pixels_ff - done_ff;
   assign remain_dec  = remain_ff - 8'd1;

   always_comb begin
      b0 = gather_ff[7:0];
      b1 = gather_ff[15:8];
      b2 = gather_ff[23:16];
      b3 = 8'd0;
      unique case (depth_ff)
         DEPTH_PAL8: b0 = req_data_byte;
         DEPTH_16:   b1 = req_data_byte;
         DEPTH_24:   b2 = req_data_byte;
         DEPTH_32:   b3 = req_data_byte;
         default:    b3 = 8'd0;
      endcase
   end

   always_comb begin
      repeat_count = 8'd1;
      clipped      = 1'b0;
      if (rle_ff) begin
         if (is_run_ff) begin
            if ({24'd0, remain_ff} > left) begin
               repeat_count = left[7:0];
               clipped      = 1'b1;
            end else begin
               repeat_count = remain_ff;
            end
         end else begin
            clipped = (left == 32'd1) && (remain_dec != 8'd0);
         end
      end
   end

   always_comb begin
      gather_in = gather_ff;
      pos_in    = pos_ff;
      remain_in = remain_ff;
      is_run_in = is_run_ff;
      done_in   = done_ff;
      if (req_accept && (req_opcode == OP_START)) begin
         gather_in = 24'd0;
         pos_in    = 2'd0;
         remain_in = 8'd0;
         is_run_in = 1'b0;
         done_in   = 32'd0;
      end else if (pixel_byte) begin
         if (header_byte) begin
            is_run_in = req_data_byte[7];
            remain_in = (req_data_byte & COUNT_MASK) + 8'd1;
         end else if (!pos_last) begin
            unique case (pos_ff)
               2'd0:    gather_in[7:0]   = gather_ff[7:0]   | req_data_byte;
               2'd1:    gather_in[15:8]  = gather_ff[15:8]  | req_data_byte;
               default: gather_in[23:16] = gather_ff[23:16] | req_data_byte;
            endcase
            pos_in = pos_ff + 2'd1;
         end else begin
            gather_in = 24'd0;
            pos_in    = 2'd0;
            done_in   = done_ff + {24'd0, repeat_count};
            if (rle_ff) begin
               remain_in = is_run_ff ? 8'd0 : remain_dec;
            end
         end
      end
   end

   always_comb begin
      pix.valid         = pixel_byte && !header_byte && pos_last;
      pix.b0            = b0;
      pix.b1            = b1;
      pix.b2            = b2;
      pix.b3            = b3;
      pix.depth         = depth_ff;
      pix.alpha_present = alpha_ff;
      pix.repeat_count  = repeat_count;
      // The repeat never exceeds what is left, so equality marks the end.
      pix.image_done    = ({24'd0, repeat_count} == left);
      pix.run_clipped   = clipped;

      palwr.valid   = req_accept && (req_opcode == OP_PALETTE);
      palwr.index   = req_palette_index;
      palwr.channel = req_palette_channel;
      palwr.data    = req_data_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff  <= DEPTH_RESET;
         alpha_ff  <= 1'b0;
         rle_ff    <= 1'b0;
         pixels_ff <= PIXELS_RESET;
         gather_ff <= 24'd0;
         pos_ff    <= 2'd0;
         remain_ff <= 8'd0;
         is_run_ff <= 1'b0;
         done_ff   <= 32'd0;
      end else begin
         depth_ff  <= depth_in;
         alpha_ff  <= alpha_in;
         rle_ff    <= rle_in;
         pixels_ff <= pixels_in;
         gather_ff <= gather_in;
         pos_ff    <= pos_in;
         remain_ff <= remain_in;
         is_run_ff <= is_run_in;
         done_ff   <= done_in;
      end
   end

endmodule

// ===== rtl/trpd_pixel.sv =====
// ============================================================================
// Palette stage
// Reads the palette RAM, merges palette byte writes back into their entry,
// decodes pixels to RGBA with the color key, and holds the result register.
// ============================================================================
module trpd_pixel #(
   parameter int PALETTE_ENTRIES = trpd_pkg::PALETTE_ENTRIES_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  trpd_pkg::trpd_pixel_type pix,
   input  trpd_pkg::trpd_palwr_type palwr,
   output logic                     hold,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_red,
   output logic [7:0]               rsp_green,
   output logic [7:0]               rsp_blue,
   output logic [7:0]               rsp_alpha,
   output logic [7:0]               rsp_repeat_count,
   output logic                     rsp_key_hit,
   output logic                     rsp_image_done,
   output logic                     rsp_run_clipped
);
   import trpd_pkg::*;

   localparam int AW = $clog2(PALETTE_ENTRIES);

   trpd_pixel_type s1_pix_ff, s1_pix_in;
   trpd_palwr_type s1_wr_ff, s1_wr_in;

   logic                     fwd_valid_ff, fwd_valid_in;
   logic [AW-1:0]            fwd_addr_ff;
   logic [PALETTE_WIDTH-1:0] fwd_data_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [7:0]               red_ff, green_ff, blue_ff, alpha_ff;
   logic [7:0]               repeat_ff;
   logic                     key_ff, done_ff, clipped_ff;

   logic [AW-1:0]            read_addr;
   logic [PALETTE_WIDTH-1:0] read_data;
   logic [AW-1:0]            s1_addr;
   logic [PALETTE_WIDTH-1:0] entry;
   logic [PALETTE_WIDTH-1:0] merged;
   logic                     write_enable;
   logic                     pix_in_range;
   logic [7:0]               red, green, blue, alpha;
   logic                     key_hit;

   assign hold = s1_pix_ff.valid && rsp_valid_ff && rsp_stall;

   // A held pixel re-reads its own entry so the read data stays current.
   always_comb begin
      if (hold) begin
         read_addr = s1_pix_ff.b0[AW-1:0];
      end else if (palwr.valid) begin
         read_addr = palwr.index[AW-1:0];
      end else begin
         read_addr = pix.b0[AW-1:0];
      end
   end

   trpd_ram #(
      .WIDTH (PALETTE_WIDTH),
      .DEPTH (PALETTE_ENTRIES)
   ) u_palette (
      .clock        (clock),
      .write_enable (write_enable),
      .write_addr   (s1_wr_ff.index[AW-1:0]),
      .write_data   (merged),
      .read_addr    (read_addr),
      .read_data    (read_data)
   );

   assign s1_addr = s1_wr_ff.valid ? s1_wr_ff.index[AW-1:0] : s1_pix_ff.b0[AW-1:0];

   // The RAM returns old data when the previous cycle wrote the same entry.
   assign entry = (fwd_valid_ff && (fwd_addr_ff == s1_addr)) ? fwd_data_ff : read_data;

   assign write_enable = s1_wr_ff.valid && (s1_wr_ff.channel != 2'd3)
                         && ({1'b0, s1_wr_ff.index} < 9'(PALETTE_ENTRIES));

   always_comb begin
      merged = entry;
      unique case (s1_wr_ff.channel)
         CHAN_BLUE:  merged[7:0]   = s1_wr_ff.data;
         CHAN_GREEN: merged[15:8]  = s1_wr_ff.data;
         CHAN_RED:   merged[23:16] = s1_wr_ff.data;
         default:    merged        = entry;
      endcase
   end

   assign pix_in_range = ({1'b0, s1_pix_ff.b0} < 9'(PALETTE_ENTRIES));

   always_comb begin
      red   = 8'd0;
      green = 8'd0;
      blue  = 8'd0;
      alpha = CHANNEL_FULL;
      unique case (s1_pix_ff.depth)
         DEPTH_PAL8: begin
            if (pix_in_range) begin
               blue  = entry[7:0];
               green = entry[15:8];
               red   = entry[23:16];
            end
         end
         DEPTH_16: begin
            red   = {s1_pix_ff.b1[6:2], 3'd0};
            green = {s1_pix_ff.b1[1:0], s1_pix_ff.b0[7:5], 3'd0};
            blue  = {s1_pix_ff.b0[4:0], 3'd0};
            if (s1_pix_ff.alpha_present) begin
               alpha = s1_pix_ff.b1[7] ? CHANNEL_FULL : 8'd0;
            end
         end
         DEPTH_24: begin
            red   = s1_pix_ff.b2;
            green = s1_pix_ff.b1;
            blue  = s1_pix_ff.b0;
         end
         default: begin
            red   = s1_pix_ff.b2;
            green = s1_pix_ff.b1;
            blue  = s1_pix_ff.b0;
            alpha = s1_pix_ff.b3;
         end
      endcase
      // Pure green is the color key and becomes transparent black.
      key_hit = (red == 8'd0) && (green == CHANNEL_FULL) && (blue == 8'd0);
      if (key_hit) begin
         green = 8'd0;
         alpha = 8'd0;
      end
   end

   always_comb begin
      s1_pix_in = s1_pix_ff;
      s1_wr_in  = palwr;
      if (!hold) begin
         s1_pix_in = pix;
      end else begin
         s1_wr_in.valid = 1'b0;
      end
      fwd_valid_in = write_enable;
      rsp_valid_in = rsp_valid_ff;
      if (s1_pix_ff.valid && !hold) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      fwd_addr_ff <= s1_wr_ff.index[AW-1:0];
      fwd_data_ff <= merged;
      if (s1_pix_ff.valid && !hold) begin
         red_ff     <= red;
         green_ff   <= green;
         blue_ff    <= blue;
         alpha_ff   <= alpha;
         repeat_ff  <= s1_pix_ff.repeat_count;
         key_ff     <= key_hit;
         done_ff    <= s1_pix_ff.image_done;
         clipped_ff <= s1_pix_ff.run_clipped;
      end
      if (reset) begin
         s1_pix_ff    <= '0;
         s1_wr_ff     <= '0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_pix_ff    <= s1_pix_in;
         s1_wr_ff     <= s1_wr_in;
         fwd_valid_ff <= fwd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_red          = red_ff;
   assign rsp_green        = green_ff;
   assign rsp_blue         = blue_ff;
   assign rsp_alpha        = alpha_ff;
   assign rsp_repeat_count = repeat_ff;
   assign rsp_key_hit      = key_ff;
   assign rsp_image_done   = done_ff;
   assign rsp_run_clipped  = clipped_ff;

endmodule
